// ----- hdl/tws_pkg.sv -----
// Shared types, codes and sizes for the tiered worker selector.
// Depends on nothing; other files refer to it by scoped name or import it.
`default_nettype none

package tws_pkg;

    // Slots per pool that an update can reach (worker_index is 3 bits)
    localparam int SLOTS   = 8;
    localparam int IDX_W   = 3;
    localparam int ADDR_W  = IDX_W + 1;
    localparam int DEPTH   = 2 * SLOTS;
    localparam int PTR_W   = 4;
    localparam int CNT_W   = 7;
    localparam int LOAD_W  = 16;
    localparam int CAP_W   = 16;
    localparam int TIME_W  = 32;

    localparam int WORKERS_POOL_A_DEF = 8;
    localparam int WORKERS_POOL_B_DEF = 8;

    localparam logic [CAP_W-1:0] CAP_RESET = 16'd64;

    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_SELECT = 1'b1;

    localparam logic CFG_CAP_A = 1'b0;
    localparam logic CFG_CAP_B = 1'b1;

    localparam logic [1:0] METHOD_AVG  = 2'd0;
    localparam logic [1:0] METHOD_LONG = 2'd1;
    localparam logic [1:0] METHOD_RR   = 2'd2;
    localparam logic [1:0] METHOD_NONE = 2'd3;

    typedef struct packed {
        logic              opcode;
        logic              pool;
        logic [IDX_W-1:0]  worker_index;
        logic [LOAD_W-1:0] held_tasks;
        logic              is_active;
        logic              is_healthy;
        logic [TIME_W-1:0] avg_task_time;
        logic [TIME_W-1:0] peak_task_time;
    } t_in_item;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] selected_index;
        logic [1:0]       method;
    } t_out_item;

    typedef struct packed {
        logic [LOAD_W-1:0] load;
        logic              active;
        logic              healthy;
        logic [TIME_W-1:0] avg_time;
        logic [TIME_W-1:0] longest_time;
    } t_entry;

    typedef struct packed {
        logic             clear;
        logic             step;
        logic [IDX_W-1:0] worker;
    } t_scan_ctl;

endpackage

`default_nettype wire

// ----- hdl/tws_scan.sv -----
// Scan accumulator: folds one status entry per stepped cycle into the three tiers.
// Depends on tws_pkg.
`default_nettype none

module tws_scan (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire tws_pkg::t_scan_ctl         i_ctl,
    input  wire tws_pkg::t_entry            i_entry,
    input  wire logic [tws_pkg::CAP_W-1:0]  i_cap,
    input  wire logic [tws_pkg::PTR_W-1:0]  i_ptr,
    output tws_pkg::t_out_item              o_pick
);

    logic                         r_have;
    logic [tws_pkg::TIME_W-1:0]   r_min_avg;
    logic [tws_pkg::IDX_W-1:0]    r_idx_avg;
    logic [tws_pkg::TIME_W-1:0]   r_min_long;
    logic [tws_pkg::IDX_W-1:0]    r_idx_long;
    logic                         r_hit_have;
    logic [tws_pkg::IDX_W-1:0]    r_hit_idx;
    logic [tws_pkg::IDX_W-1:0]    r_first_idx;
    logic                         eligible;
    logic                         at_or_past_ptr;

    assign eligible = i_entry.active && i_entry.healthy && (i_entry.load < i_cap);
    assign at_or_past_ptr = {1'b0, i_ctl.worker} >= i_ptr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have     <= 1'b0;
            r_hit_have <= 1'b0;
        end else if (i_ctl.clear) begin
            r_have     <= 1'b0;
            r_hit_have <= 1'b0;
        end else if (i_ctl.step && eligible) begin
            r_have <= 1'b1;
            // strict compare: ties stay with the lower index
            if (!r_have || i_entry.avg_time < r_min_avg) begin
                r_min_avg <= i_entry.avg_time;
                r_idx_avg <= i_ctl.worker;
            end
            if (!r_have || i_entry.longest_time < r_min_long) begin
                r_min_long <= i_entry.longest_time;
                r_idx_long <= i_ctl.worker;
            end
            if (!r_have) begin
                r_first_idx <= i_ctl.worker;
            end
            if (!r_hit_have && at_or_past_ptr) begin
                r_hit_have <= 1'b1;
                r_hit_idx  <= i_ctl.worker;
            end
        end
    end

    always_comb begin
        o_pick = '0;
        priority if (r_have && r_min_avg != '0) begin
            o_pick.found          = 1'b1;
            o_pick.selected_index = r_idx_avg;
            o_pick.method         = tws_pkg::METHOD_AVG;
        end else if (r_have && r_min_long != '0) begin
            o_pick.found          = 1'b1;
            o_pick.selected_index = r_idx_long;
            o_pick.method         = tws_pkg::METHOD_LONG;
        end else if (r_have) begin
            // wrap to the first eligible worker when none sits at or past the pointer
            o_pick.found          = 1'b1;
            o_pick.selected_index = r_hit_have ? r_hit_idx : r_first_idx;
            o_pick.method         = tws_pkg::METHOD_RR;
        end else begin
            o_pick.found          = 1'b0;
            o_pick.selected_index = '0;
            o_pick.method         = tws_pkg::METHOD_NONE;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/tiered_worker_selector_core.sv -----
// An update is written in the cycle of its transfer. A select reads
//   N = min(pool size, 8) entries through the single read port of the status
//   memory, folds the registered read data into the tier accumulator, then hands
//   the pick to the output register once it is free; the input is stalled until
//   then, so a new item waits for the select to finish. One update per cycle when idle.
// Reset: synchronous, active low; clears valid bits and pointers, sets capacities to 64.
`default_nettype none

module tiered_worker_selector_core #(
    parameter int WORKERS_POOL_A = tws_pkg::WORKERS_POOL_A_DEF,
    parameter int WORKERS_POOL_B = tws_pkg::WORKERS_POOL_B_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    // input item channel
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire tws_pkg::t_in_item         i_in_data,
    // result channel
    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output tws_pkg::t_out_item             o_out_data,
    // configuration writes
    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic                      i_cfg_index,
    input  wire logic [tws_pkg::CAP_W-1:0] i_cfg_data
);

    // Pool sizes as counts; workers beyond the reachable slots are never
    // written, stay inactive and so never win, so the scan stops at the slots.
    localparam logic [tws_pkg::CNT_W-1:0] POOL_N_A = tws_pkg::CNT_W'(WORKERS_POOL_A);
    localparam logic [tws_pkg::CNT_W-1:0] POOL_N_B = tws_pkg::CNT_W'(WORKERS_POOL_B);
    localparam logic [tws_pkg::PTR_W-1:0] SCAN_N_A = tws_pkg::PTR_W'(
        (WORKERS_POOL_A < tws_pkg::SLOTS) ? WORKERS_POOL_A : tws_pkg::SLOTS);
    localparam logic [tws_pkg::PTR_W-1:0] SCAN_N_B = tws_pkg::PTR_W'(
        (WORKERS_POOL_B < tws_pkg::SLOTS) ? WORKERS_POOL_B : tws_pkg::SLOTS);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0]                      r_state;
    logic [1:0]                      n_state;

    logic [tws_pkg::CAP_W-1:0]       r_cap_a;
    logic [tws_pkg::CAP_W-1:0]       r_cap_b;
    logic [tws_pkg::PTR_W-1:0]       r_ptr_a;
    logic [tws_pkg::PTR_W-1:0]       r_ptr_b;

    // status memory: one entry per {pool, worker}, no reset on the array
    tws_pkg::t_entry                 mem [tws_pkg::DEPTH];
    logic [tws_pkg::DEPTH-1:0]       r_ent_vld;
    tws_pkg::t_entry                 r_rd_data;
    logic                            r_rd_live;
    logic                            r_rd_valid;
    logic [tws_pkg::IDX_W-1:0]       r_rd_w;

    logic                            r_pool;
    logic [tws_pkg::PTR_W-1:0]       r_issue;
    logic [tws_pkg::PTR_W-1:0]       r_scan_n;

    tws_pkg::t_out_item              r_out;
    logic                            r_out_valid;

    logic                            in_xfer;
    logic                            is_update;
    logic                            is_select;
    logic                            in_range;
    logic                            wr_en;
    logic [tws_pkg::ADDR_W-1:0]      wr_addr;
    logic [tws_pkg::ADDR_W-1:0]      rd_addr;
    logic                            issue;
    logic                            out_free;
    logic                            finish;
    tws_pkg::t_entry                 wr_entry;
    tws_pkg::t_entry                 scan_entry;
    tws_pkg::t_scan_ctl              scan_ctl;
    tws_pkg::t_out_item              pick;
    logic [tws_pkg::CAP_W-1:0]       cur_cap;
    logic [tws_pkg::PTR_W-1:0]       cur_ptr;
    logic [tws_pkg::PTR_W-1:0]       ptr_inc;
    logic [tws_pkg::PTR_W-1:0]       ptr_next;
    logic [tws_pkg::CNT_W-1:0]       cur_n;

    // ---------------------------------------------------------------
    // Handshakes
    // ---------------------------------------------------------------
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign is_update   = in_xfer && (i_in_data.opcode == tws_pkg::OP_UPDATE);
    assign is_select   = in_xfer && (i_in_data.opcode == tws_pkg::OP_SELECT);

    // Drop updates aimed past the end of the pool
    assign in_range = i_in_data.pool
                    ? (tws_pkg::CNT_W'(i_in_data.worker_index) < POOL_N_B)
                    : (tws_pkg::CNT_W'(i_in_data.worker_index) < POOL_N_A);
    assign wr_en    = is_update && in_range;
    assign wr_addr  = {i_in_data.pool, i_in_data.worker_index};

    always_comb begin
        wr_entry.load         = i_in_data.held_tasks;
        wr_entry.active       = i_in_data.is_active;
        wr_entry.healthy      = i_in_data.is_healthy;
        wr_entry.avg_time     = i_in_data.avg_task_time;
        wr_entry.longest_time = i_in_data.peak_task_time;
    end

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap_a <= tws_pkg::CAP_RESET;
            r_cap_b <= tws_pkg::CAP_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                tws_pkg::CFG_CAP_A: r_cap_a <= i_cfg_data;
                tws_pkg::CFG_CAP_B: r_cap_b <= i_cfg_data;
                default:            r_cap_a <= r_cap_a;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Status memory: write on update, one registered read per cycle.
    // A select never overlaps an update (input held off during the scan),
    // so a read always sees every earlier write.
    // ---------------------------------------------------------------
    assign rd_addr = {r_pool, r_issue[tws_pkg::IDX_W-1:0]};
    assign issue   = (r_state == ST_SCAN) && (r_issue < r_scan_n);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_entry;
        end
        r_rd_data <= mem[rd_addr];
    end

    // Valid bits stand in for the all-zero reset of the table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent_vld <= '0;
            r_rd_live <= 1'b0;
        end else begin
            if (wr_en) begin
                r_ent_vld[wr_addr] <= 1'b1;
            end
            r_rd_live <= r_ent_vld[rd_addr];
        end
    end

    assign scan_entry = r_rd_live ? r_rd_data : '0;

    // ---------------------------------------------------------------
    // Sequencer: issue addresses 0..N-1, then wait for the last read data
    // to be folded in, then hand the pick to the output register.
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid <= 1'b0;
        end else begin
            r_rd_valid <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (is_select) begin
            r_pool   <= i_in_data.pool;
            r_issue  <= '0;
            r_scan_n <= i_in_data.pool ? SCAN_N_B : SCAN_N_A;
        end else if (issue) begin
            r_issue <= r_issue + 1'b1;
        end
        r_rd_w <= r_issue[tws_pkg::IDX_W-1:0];
    end

    assign out_free = !r_out_valid || !i_out_stall;
    assign finish   = (r_state == ST_FINISH) && out_free;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (is_select) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (!issue && !r_rd_valid) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---------------------------------------------------------------
    // Tier accumulator
    // ---------------------------------------------------------------
    assign cur_cap = r_pool ? r_cap_b : r_cap_a;
    assign cur_ptr = r_pool ? r_ptr_b : r_ptr_a;
    assign cur_n   = r_pool ? POOL_N_B : POOL_N_A;

    always_comb begin
        scan_ctl.clear  = is_select;
        scan_ctl.step   = r_rd_valid;
        scan_ctl.worker = r_rd_w;
    end

    tws_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (scan_ctl),
        .i_entry (scan_entry),
        .i_cap   (cur_cap),
        .i_ptr   (cur_ptr),
        .o_pick  (pick)
    );

    // ---------------------------------------------------------------
    // Round-robin pointers: advance past a round-robin pick, wrap at pool size
    // ---------------------------------------------------------------
    assign ptr_inc  = {1'b0, pick.selected_index} + 1'b1;
    assign ptr_next = (tws_pkg::CNT_W'(ptr_inc) == cur_n) ? '0 : ptr_inc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr_a <= '0;
            r_ptr_b <= '0;
        end else if (finish && pick.method == tws_pkg::METHOD_RR) begin
            if (r_pool) begin
                r_ptr_b <= ptr_next;
            end else begin
                r_ptr_a <= ptr_next;
            end
        end
    end

    // ---------------------------------------------------------------
    // Output register: hold the result until the transfer completes
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_out <= pick;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// ----- hdl/tws_checker.sv -----
// Port-level checks for the tiered worker selector, bound to the top level.
// Depends on tws_pkg and tiered_worker_selector_core.
`default_nettype none

module tws_checker (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      i_in_valid,
    input wire logic                      o_in_stall,
    input wire tws_pkg::t_in_item         i_in_data,
    input wire logic                      o_out_valid,
    input wire logic                      i_out_stall,
    input wire tws_pkg::t_out_item        o_out_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // no pick means index zero and method none
    a_none_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.found |->
            o_out_data.selected_index == '0 && o_out_data.method == tws_pkg::METHOD_NONE)
        else $error("empty result malformed");

    // a pick never reports method none
    a_found_method: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.found |-> o_out_data.method != tws_pkg::METHOD_NONE)
        else $error("found result with method none");

    // a select holds off the next transfer while it scans
    a_select_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in_data.opcode == tws_pkg::OP_SELECT |=> o_in_stall)
        else $error("input taken during a scan");

endmodule

bind tiered_worker_selector_core tws_checker u_tws_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

`default_nettype wire

// ----- dv/tws_selection_checker.sv -----
// Checker for the tiered worker selector: tracks the status table, predicts each pick
// and compares it with the result channel. Depends on tws_pkg for item types and codes.
`timescale 1ns / 1ps

module tws_selection_checker #(
    parameter int WORKERS_POOL_A = tws_pkg::WORKERS_POOL_A_DEF,
    parameter int WORKERS_POOL_B = tws_pkg::WORKERS_POOL_B_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic                      i_in_stall,
    input  tws_pkg::t_in_item         i_in_data,
    input  logic                      i_out_valid,
    input  logic                      i_out_stall,
    input  tws_pkg::t_out_item        i_out_data,
    input  logic                      i_cfg_valid,
    input  logic                      i_cfg_ready,
    input  logic                      i_cfg_index,
    input  logic [tws_pkg::CAP_W-1:0] i_cfg_data,
    output int                        o_fail_count,
    output int                        o_pending
);
    import tws_pkg::*;

    logic [LOAD_W-1:0] load_tbl    [2][SLOTS];
    logic              active_tbl  [2][SLOTS];
    logic              healthy_tbl [2][SLOTS];
    logic [TIME_W-1:0] avg_tbl     [2][SLOTS];
    logic [TIME_W-1:0] longest_tbl [2][SLOTS];
    logic [CAP_W-1:0]  capacity    [2];
    int                rr_next     [2];

    t_out_item expected_picks[$];
    int        mismatches = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic int pool_size(input int p);
        int n;
        n = p ? WORKERS_POOL_B : WORKERS_POOL_A;
        if (n > SLOTS) n = SLOTS;
        if (n < 1) n = 1;
        return n;
    endfunction

    function automatic logic is_eligible(input int p, input int w);
        return load_tbl[p][w] < capacity[p] && active_tbl[p][w] && healthy_tbl[p][w];
    endfunction

    // lowest time among eligible workers, first index wins a tie
    function automatic logic find_lowest(input int p, input logic by_longest,
                                         output int idx, output logic [TIME_W-1:0] low_val);
        logic              have;
        logic [TIME_W-1:0] v;
        have    = 1'b0;
        idx     = 0;
        low_val = '0;
        for (int w = 0; w < pool_size(p); w++) begin
            v = by_longest ? longest_tbl[p][w] : avg_tbl[p][w];
            if (is_eligible(p, w) && (!have || v < low_val)) begin
                have    = 1'b1;
                low_val = v;
                idx     = w;
            end
        end
        return have;
    endfunction

    function automatic t_out_item pick_worker(input int p);
        t_out_item         pick;
        int                idx, n, w;
        logic [TIME_W-1:0] low_val;
        n          = pool_size(p);
        pick.found = 1'b1;
        if (find_lowest(p, 1'b0, idx, low_val) && low_val != 0) begin
            pick.selected_index = idx[IDX_W-1:0];
            pick.method         = METHOD_AVG;
            return pick;
        end
        if (find_lowest(p, 1'b1, idx, low_val) && low_val != 0) begin
            pick.selected_index = idx[IDX_W-1:0];
            pick.method         = METHOD_LONG;
            return pick;
        end
        // round robin: advance the pointer past the worker taken
        for (int i = 0; i < n; i++) begin
            w = (rr_next[p] % n + i) % n;
            if (is_eligible(p, w)) begin
                rr_next[p]          = (w + 1) % n;
                pick.selected_index = w[IDX_W-1:0];
                pick.method         = METHOD_RR;
                return pick;
            end
        end
        pick.found          = 1'b0;
        pick.selected_index = '0;
        pick.method         = METHOD_NONE;
        return pick;
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatches < 100) $display("%0t mismatch: %s", $time, what);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        int        p, w;
        if (!i_rst_n) begin
            for (p = 0; p < 2; p++) begin
                for (w = 0; w < SLOTS; w++) begin
                    load_tbl[p][w]    = '0;
                    active_tbl[p][w]  = 1'b0;
                    healthy_tbl[p][w] = 1'b0;
                    avg_tbl[p][w]     = '0;
                    longest_tbl[p][w] = '0;
                end
                capacity[p] = CAP_RESET;
                rr_next[p]  = 0;
            end
            expected_picks.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_CAP_A) capacity[0] = i_cfg_data;
                else                          capacity[1] = i_cfg_data;
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_picks.size() == 0) begin
                    report_mismatch($sformatf("result %p with no selection outstanding",
                                              i_out_data));
                end else begin
                    want = expected_picks.pop_front();
                    if (i_out_data.found !== want.found)
                        report_mismatch($sformatf("found %b, expected %b",
                                                  i_out_data.found, want.found));
                    if (i_out_data.selected_index !== want.selected_index)
                        report_mismatch($sformatf("selected_index %0d, expected %0d",
                                                  i_out_data.selected_index,
                                                  want.selected_index));
                    if (i_out_data.method !== want.method)
                        report_mismatch($sformatf("method %0d, expected %0d",
                                                  i_out_data.method, want.method));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                p = int'(i_in_data.pool);
                w = int'(i_in_data.worker_index);
                if (i_in_data.opcode == OP_SELECT) begin
                    expected_picks.push_back(pick_worker(p));
                end else if (w < pool_size(p)) begin
                    load_tbl[p][w]    = i_in_data.held_tasks;
                    active_tbl[p][w]  = i_in_data.is_active;
                    healthy_tbl[p][w] = i_in_data.is_healthy;
                    avg_tbl[p][w]     = i_in_data.avg_task_time;
                    longest_tbl[p][w] = i_in_data.peak_task_time;
                end
            end
        end
        o_pending    <= expected_picks.size();
        o_fail_count <= mismatches;
    end

endmodule

// ----- dv/tb_tiered_worker_selector_core.sv -----
// Top of the selector testbench: clock, reset, stimulus, output stalls and verdict.
// Depends on tws_pkg, tiered_worker_selector_core and tws_selection_checker.
`timescale 1ns / 1ps

module tb_tiered_worker_selector_core;
    import tws_pkg::*;

    localparam int RANDOM_ITEMS  = 480;
    localparam int PHASES        = 6;
    localparam int HOLD_CYCLES   = 300;   // long receiver hold-off, fills the block
    localparam int SETTLE_CYCLES = 24;    // comfortably longer than a select takes

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic             in_stall;
    t_in_item         in_data   = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    t_out_item        out_data;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic             cfg_index = CFG_CAP_A;
    logic [CAP_W-1:0] cfg_data  = '0;

    int fail_count;
    int pending;

    // handshake between stimulus and the stall process for the long hold-off
    logic hold_off_req  = 1'b0;
    logic hold_off_done = 1'b0;

    // sender burst state
    int burst_left = 0;
    int gap_left   = 0;

    logic [CAP_W-1:0] cap_now [2] = '{CAP_RESET, CAP_RESET};

    tiered_worker_selector_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    tws_selection_checker u_pick_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin : clock_gen
        forever #4 clk = ~clk;
    end

    // Hard stop: generous against the slowest correct run.
    initial begin : run_limit
        #4_000_000;
        $display("FAIL tiered_worker_selector_core");
        $finish;
    end

    // Receiver: alternate stretches of no stalls, light, heavy and full stalls.
    // Once asked, hold off for a long stretch so the block backs up and stalls its input.
    initial begin : result_stall_gen
        int mode, span;
        forever begin
            if (hold_off_req && !hold_off_done) begin
                repeat (HOLD_CYCLES) begin
                    @(posedge clk);
                    out_stall <= 1'b1;
                end
                hold_off_done = 1'b1;
            end else begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(4, 60);
                repeat (span) begin
                    @(posedge clk);
                    case (mode)
                        0:       out_stall <= 1'b0;
                        1:       out_stall <= ($urandom_range(0, 3) == 0);
                        2:       out_stall <= ($urandom_range(0, 3) != 0);
                        default: out_stall <= 1'b1;
                    endcase
                end
            end
        end
    end

    function automatic t_in_item make_update(input logic p, input logic [IDX_W-1:0] w,
                                             input logic [LOAD_W-1:0] load,
                                             input logic act, input logic hlth,
                                             input logic [TIME_W-1:0] avg,
                                             input logic [TIME_W-1:0] lng);
        t_in_item it;
        it.opcode         = OP_UPDATE;
        it.pool           = p;
        it.worker_index   = w;
        it.held_tasks     = load;
        it.is_active      = act;
        it.is_healthy     = hlth;
        it.avg_task_time  = avg;
        it.peak_task_time = lng;
        return it;
    endfunction

    // Select items carry random junk in the fields that a select ignores.
    function automatic t_in_item make_select(input logic p);
        t_in_item    it;
        logic [95:0] junk;
        junk                 = {$urandom, $urandom, $urandom};
        it                   = junk[$bits(t_in_item)-1:0];
        it.opcode            = OP_SELECT;
        it.pool              = p;
        return it;
    endfunction

    // Lean towards zero and small values so that ties and the zero-minimum
    // fall-through between tiers turn up often.
    function automatic logic [TIME_W-1:0] random_time();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return $urandom_range(1, 6);
            2:       return $urandom;
            3:       return '1;
            default: return $urandom_range(0, 3);
        endcase
    endfunction

    function automatic logic [LOAD_W-1:0] random_load(input logic p);
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return cap_now[p] - 1'b1;
            2:       return cap_now[p];
            3:       return LOAD_W'($urandom_range(0, 65535));
            4:       return LOAD_W'($urandom_range(0, 8));
            default: return '1;
        endcase
    endfunction

    function automatic logic [CAP_W-1:0] random_capacity();
        case ($urandom_range(0, 6))
            0:       return '0;
            1:       return 16'd1;
            2:       return 16'd2;
            3:       return CAP_RESET;
            4:       return '1;
            5:       return CAP_W'($urandom_range(3, 16));
            default: return CAP_W'($urandom_range(1, 65535));
        endcase
    endfunction

    function automatic t_in_item random_item();
        logic p;
        p = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 9) < 4) return make_select(p);
        return make_update(p, IDX_W'($urandom_range(0, 7)), random_load(p),
                           $urandom_range(0, 4) != 0, $urandom_range(0, 4) != 0,
                           random_time(), random_time());
    endfunction

    // Offer one item and hold it until the transfer. Bursts of random length are
    // separated by random gaps; some bursts follow straight on with no gap.
    task automatic offer_item(input t_in_item item);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
        if (gap_left > 0) begin
            in_valid <= 1'b0;
            repeat (gap_left) @(posedge clk);
            gap_left = 0;
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (in_stall);
        burst_left--;
    endtask

    // Drain: wait for every outstanding pick, then let the block settle so that
    // a trailing update has certainly landed before anything else happens.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write the capacity registers picked by mask, back to back, only when idle.
    task automatic set_capacities(input logic [1:0] mask, input logic [CAP_W-1:0] cap_a,
                                  input logic [CAP_W-1:0] cap_b);
        for (int r = 0; r < 2; r++) begin
            if (mask[r]) begin
                cfg_valid <= 1'b1;
                cfg_index <= r ? CFG_CAP_B : CFG_CAP_A;
                cfg_data  <= r ? cap_b : cap_a;
                do @(posedge clk); while (!cfg_ready);
                cap_now[r] = r ? cap_b : cap_a;
            end
        end
        cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        int per_phase;
        per_phase = RANDOM_ITEMS / PHASES;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table after reset: nothing eligible in either pool
        offer_item(make_select(1'b0));
        offer_item(make_select(1'b1));
        // one eligible worker with zero times: round robin, twice round
        offer_item(make_update(1'b0, 3'd0, 16'd0, 1'b1, 1'b1, 32'd0, 32'd0));
        offer_item(make_select(1'b0));
        offer_item(make_select(1'b0));
        // load just under capacity, times at full scale; the zero minima fall through
        offer_item(make_update(1'b0, 3'd7, 16'd63, 1'b1, 1'b1, '1, '1));
        offer_item(make_select(1'b0));
        // tie on average time goes to the lower index
        offer_item(make_update(1'b0, 3'd0, 16'd0, 1'b1, 1'b1, 32'd5, 32'd3));
        offer_item(make_update(1'b0, 3'd3, 16'd1, 1'b1, 1'b1, 32'd5, 32'd9));
        offer_item(make_select(1'b0));
        // drop the winner by health, then another by activity
        offer_item(make_update(1'b0, 3'd0, 16'd0, 1'b1, 1'b0, 32'd5, 32'd3));
        offer_item(make_select(1'b0));
        offer_item(make_update(1'b0, 3'd3, 16'd1, 1'b0, 1'b1, 32'd5, 32'd9));
        offer_item(make_select(1'b0));
        // second pool: zero average minimum, longest time decides
        offer_item(make_update(1'b1, 3'd1, 16'd0, 1'b1, 1'b1, 32'd0, 32'd7));
        offer_item(make_update(1'b1, 3'd4, 16'd2, 1'b1, 1'b1, 32'd0, 32'd2));
        offer_item(make_update(1'b1, 3'd5, 16'd64, 1'b1, 1'b1, 32'd1, 32'd1));
        offer_item(make_select(1'b1));
        offer_item(make_update(1'b1, 3'd2, 16'hFFFF, 1'b1, 1'b1, 32'd3, 32'd0));
        offer_item(make_select(1'b1));

        // zero capacity on the first pool, largest on the second
        wait_idle();
        set_capacities(2'b11, 16'd0, 16'hFFFF);
        offer_item(make_select(1'b0));
        offer_item(make_update(1'b1, 3'd6, 16'hFFFE, 1'b1, 1'b1, 32'd0, 32'd0));
        offer_item(make_select(1'b1));

        // smallest non-zero capacity on both pools
        wait_idle();
        set_capacities(2'b11, 16'd1, 16'd1);
        offer_item(make_select(1'b0));
        offer_item(make_select(1'b1));

        // Random phases, each under its own capacity setting. The long hold-off
        // is requested early in the third phase while the sender keeps offering.
        for (int ph = 0; ph < PHASES; ph++) begin
            wait_idle();
            set_capacities(2'($urandom_range(1, 3)), random_capacity(), random_capacity());
            if (ph == 2) hold_off_req = 1'b1;
            repeat (per_phase) offer_item(random_item());
        end

        wait_idle();
        if (fail_count == 0) begin
            $display("PASS tiered_worker_selector_core");
        end else begin
            $display("FAIL tiered_worker_selector_core");
        end
        $finish;
    end

endmodule
